@@ src/wsts_pkg.sv @@
package wsts_pkg;

    localparam int WORKER_COUNT = 4;
    localparam int DEQUE_DEPTH = 16;
    localparam int TASK_BITS   = 16;

    localparam int WID_W  = (WORKER_COUNT > 1) ? $clog2(WORKER_COUNT) : 1;
    localparam int NUM_W  = WID_W + 1;
    localparam int PTR_W  = $clog2(DEQUE_DEPTH);
    localparam int CNT_W  = PTR_W + 1;
    localparam int STORE_DEPTH = WORKER_COUNT * DEQUE_DEPTH;
    localparam int ADDR_W = $clog2(STORE_DEPTH);

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 3;
    localparam int ACT_W    = 3;
    localparam int OUT_TASK_W = 16;
    localparam int OUT_SRC_W  = 2;
    localparam logic [ACT_W-1:0] ACT_RESET = ACT_W'(4);

    typedef enum logic [CMD_W-1:0] {
        CMD_SUBMIT   = 2'd0,
        CMD_REQUEST  = 2'd1,
        CMD_SHUTDOWN = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED    = 3'd0,
        ST_DROP_SHUT = 3'd1,
        ST_DROP_FULL = 3'd2,
        ST_LOCAL     = 3'd3,
        ST_STOLEN    = 3'd4,
        ST_WAIT      = 3'd5,
        ST_EXIT      = 3'd6,
        ST_BAD       = 3'd7
    } status_t;

    typedef enum logic [0:0] {
        S_IDLE = 1'b0,
        S_OUT  = 1'b1
    } state_t;

    typedef struct packed {
        logic take_word;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic no_result;
    } dp_stat_t;

endpackage

@@ src/wsts_ram.sv @@
module wsts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ src/wsts_ctrl.sv @@
module wsts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  wsts_pkg::dp_stat_t  stat,
    output wsts_pkg::ctrl_cmd_t ctl
);
    import wsts_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !stat.no_result)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        ctl.take_word = 1'b0;
        ctl.load_out  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready      = 1'b1;
                ctl.take_word = in_valid;
            end
            S_OUT:
            begin
                ctl.load_out = out_free;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (ctl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ src/wsts_datapath.sv @@
module wsts_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wsts_pkg::ACT_W-1:0]          cfg_data,
    input  logic [wsts_pkg::CMD_W-1:0]          cmd,
    input  logic [wsts_pkg::WID_W-1:0]          worker_id,
    input  logic [wsts_pkg::TASK_BITS-1:0]      task_id,
    output logic [wsts_pkg::STATUS_W-1:0]       status,
    output logic [wsts_pkg::OUT_TASK_W-1:0]     task_out,
    output logic [wsts_pkg::OUT_SRC_W-1:0]      source_worker,
    input  wsts_pkg::ctrl_cmd_t                 ctl,
    output wsts_pkg::dp_stat_t                  stat
);
    import wsts_pkg::*;

    logic [PTR_W-1:0]     head_reg  [WORKER_COUNT];
    logic [PTR_W-1:0]     head_next [WORKER_COUNT];
    logic [CNT_W-1:0]     count_reg  [WORKER_COUNT];
    logic [CNT_W-1:0]     count_next [WORKER_COUNT];
    logic [WID_W-1:0]     rr_reg;
    logic [WID_W-1:0]     rr_next;
    logic                 shut_reg;
    logic                 shut_next;
    logic [ACT_W-1:0]     act_reg;

    status_t              res_status_reg;
    status_t              res_status_next;
    logic [TASK_BITS-1:0] res_task_reg;
    logic [TASK_BITS-1:0] res_task_next;
    logic [WID_W-1:0]     res_src_reg;
    logic [WID_W-1:0]     res_src_next;
    logic                 res_mem_reg;
    logic                 res_mem_next;

    logic [STATUS_W-1:0]   out_status_reg;
    logic [OUT_TASK_W-1:0] out_task_reg;
    logic [OUT_SRC_W-1:0]  out_src_reg;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic                 mem_re;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [TASK_BITS-1:0] mem_rdata;

    logic [NUM_W-1:0]     n_eff;
    logic [WID_W-1:0]     tgt;
    logic [NUM_W-1:0]     tgt_inc;
    logic [NUM_W-1:0]     scan_sum;
    logic [WID_W-1:0]     scan_v;
    logic                 found;
    logic [WID_W-1:0]     victim;
    logic [PTR_W-1:0]     pos;

    // effective worker count
    always_comb
    begin
        if (act_reg == '0)
        begin
            n_eff = NUM_W'(1);
        end
        else if (ACT_W'(act_reg) > ACT_W'(WORKER_COUNT))
        begin
            n_eff = NUM_W'(WORKER_COUNT);
        end
        else
        begin
            n_eff = NUM_W'(act_reg);
        end
    end

    assign tgt     = (NUM_W'(rr_reg) < n_eff) ? rr_reg : '0;
    assign tgt_inc = NUM_W'(tgt) + NUM_W'(1);

    // steal scan, cyclic from worker+1
    always_comb
    begin
        found    = 1'b0;
        victim   = '0;
        scan_sum = '0;
        scan_v   = '0;
        for (int i = 1; i < WORKER_COUNT; i++)
        begin
            scan_sum = NUM_W'(worker_id) + NUM_W'(i);
            if (scan_sum >= n_eff)
            begin
                scan_v = WID_W'(scan_sum - n_eff);
            end
            else
            begin
                scan_v = WID_W'(scan_sum);
            end
            if (!found && (NUM_W'(i) < n_eff) && (count_reg[scan_v] != '0))
            begin
                found  = 1'b1;
                victim = scan_v;
            end
        end
    end

    always_comb
    begin
        for (int w = 0; w < WORKER_COUNT; w++)
        begin
            head_next[w]  = head_reg[w];
            count_next[w] = count_reg[w];
        end
        rr_next         = rr_reg;
        shut_next       = shut_reg;
        res_status_next = res_status_reg;
        res_task_next   = res_task_reg;
        res_src_next    = res_src_reg;
        res_mem_next    = res_mem_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_waddr       = '0;
        mem_raddr       = '0;
        pos             = '0;
        stat.no_result  = (cmd == CMD_NONE);

        if (ctl.take_word)
        begin
            res_mem_next  = 1'b0;
            res_task_next = '0;
            res_src_next  = '0;
            case (cmd)
                CMD_SUBMIT:
                begin
                    res_task_next = task_id;
                    if (shut_reg)
                    begin
                        res_status_next = ST_DROP_SHUT;
                    end
                    else
                    begin
                        rr_next      = (tgt_inc < n_eff) ? WID_W'(tgt_inc) : '0;
                        res_src_next = tgt;
                        if (count_reg[tgt] >= CNT_W'(DEQUE_DEPTH))
                        begin
                            res_status_next = ST_DROP_FULL;
                        end
                        else
                        begin
                            pos             = head_reg[tgt] + count_reg[tgt][PTR_W-1:0];
                            mem_we          = 1'b1;
                            mem_waddr       = {tgt, pos};
                            count_next[tgt] = count_reg[tgt] + CNT_W'(1);
                            res_status_next = ST_QUEUED;
                        end
                    end
                end
                CMD_REQUEST:
                begin
                    if (NUM_W'(worker_id) >= n_eff)
                    begin
                        res_status_next = ST_BAD;
                    end
                    else if (count_reg[worker_id] != '0)
                    begin
                        // local pop at the back
                        pos = head_reg[worker_id]
                            + PTR_W'(count_reg[worker_id] - CNT_W'(1));
                        mem_re                = 1'b1;
                        mem_raddr             = {worker_id, pos};
                        count_next[worker_id] = count_reg[worker_id] - CNT_W'(1);
                        res_status_next       = ST_LOCAL;
                        res_src_next          = worker_id;
                        res_mem_next          = 1'b1;
                    end
                    else if (found)
                    begin
                        // steal at the front
                        mem_re             = 1'b1;
                        mem_raddr          = {victim, head_reg[victim]};
                        head_next[victim]  = head_reg[victim] + PTR_W'(1);
                        count_next[victim] = count_reg[victim] - CNT_W'(1);
                        res_status_next    = ST_STOLEN;
                        res_src_next       = victim;
                        res_mem_next       = 1'b1;
                    end
                    else
                    begin
                        res_status_next = shut_reg ? ST_EXIT : ST_WAIT;
                    end
                end
                CMD_SHUTDOWN:
                begin
                    shut_next       = 1'b1;
                    res_status_next = ST_EXIT;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < WORKER_COUNT; w++)
            begin
                head_reg[w]  <= '0;
                count_reg[w] <= '0;
            end
            rr_reg   <= '0;
            shut_reg <= 1'b0;
            act_reg  <= ACT_RESET;
        end
        else
        begin
            for (int w = 0; w < WORKER_COUNT; w++)
            begin
                head_reg[w]  <= head_next[w];
                count_reg[w] <= count_next[w];
            end
            rr_reg   <= rr_next;
            shut_reg <= shut_next;
            if (cfg_we)
            begin
                act_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_task_reg   <= res_task_next;
        res_src_reg    <= res_src_next;
        res_mem_reg    <= res_mem_next;
        if (ctl.load_out)
        begin
            out_status_reg <= STATUS_W'(res_status_reg);
            out_task_reg   <= OUT_TASK_W'(res_mem_reg ? mem_rdata : res_task_reg);
            out_src_reg    <= OUT_SRC_W'(res_src_reg);
        end
    end

    wsts_ram #(
        .WIDTH (TASK_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (task_id),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign status        = out_status_reg;
    assign task_out      = out_task_reg;
    assign source_worker = out_src_reg;

endmodule

@@ src/work_stealing_task_scheduler_core.sv @@
// Work-stealing dispatcher for four workers, each owning a sixteen-entry deque of task ids
// held in one shared RAM. Every word accepted on the input gives one result word, except
// command 3, which is dropped with no result. When a word is accepted, the deque pointers,
// the steal scan and the RAM access are resolved and registered; the result, with the RAM's
// registered read data, then goes into the output register once that register is free.
// The next word is taken only once that result is loaded: no new word is taken while
// the last is in flight, and the load waits while an older result waits for out_ready.
// active_workers may be written only while the block is idle.
module work_stealing_task_scheduler_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [wsts_pkg::ACT_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [wsts_pkg::CMD_W-1:0]          cmd,
    input  logic [wsts_pkg::WID_W-1:0]          worker_id,
    input  logic [wsts_pkg::TASK_BITS-1:0]      task_id,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [wsts_pkg::STATUS_W-1:0]       status,
    output logic [wsts_pkg::OUT_TASK_W-1:0]     task_out,
    output logic [wsts_pkg::OUT_SRC_W-1:0]      source_worker
);
    import wsts_pkg::*;

    ctrl_cmd_t ctl;
    dp_stat_t  stat;

    wsts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .ctl       (ctl)
    );

    wsts_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .worker_id     (worker_id),
        .task_id       (task_id),
        .status        (status),
        .task_out      (task_out),
        .source_worker (source_worker),
        .ctl           (ctl),
        .stat          (stat)
    );

endmodule
